// File: src/integral_image_generator_defines.svh
// integral_image_generator_defines.svh: assertion macros for the integral image checker
// depends on: aclk and aresetn being visible where the macros are used
`ifndef INTEGRAL_IMAGE_GENERATOR_DEFINES_SVH
`define INTEGRAL_IMAGE_GENERATOR_DEFINES_SVH

// property checked outside reset
`define IIG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define IIG_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: src/iig_pkg.sv
// iig_pkg.sv: shared constants, types and helpers of the integral image generator
// depends on: nothing
`default_nettype none

package iig_pkg;

    // image limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // field widths
    localparam int CFG_W      = 11;
    localparam int PIX_W      = 8;
    localparam int AREA_W     = 28;
    localparam int SQUARE_W   = 36;
    localparam int RSUM_W     = PIX_W + COL_W;
    localparam int RSQ_W      = 2 * PIX_W + COL_W;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified pixel on its way to the back end
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic              first_row;
        logic              frame_end;
        logic [RSUM_W-1:0] rsum;
        logic [RSQ_W-1:0]  rsq;
    } pix_entry_t;

    // last index of a dimension: zero acts as one, oversize saturates at the limit
    function automatic int size_last(input logic [CFG_W-1:0] v, input int limit);
        int last;
        if (v == '0) begin
            last = 0;
        end else if (int'(v) > limit) begin
            last = limit - 1;
        end else begin
            last = int'(v) - 1;
        end
        return last;
    endfunction

endpackage

`default_nettype wire

// File: src/integral_image_generator.sv
// Integral image generator: 8-bit pixels in raster order in, summed-area value and
// summed-area value of squared pixels out, one result transaction per pixel.
// Input channel s_valid/s_ready carries s_pixel; result channel m_valid/m_ready
// carries m_area_sum, m_square_sum and m_frame_end (high on the last pixel of a frame).
// cfg_wr_en writes cfg_data into image_width (index 0) or image_height (index 1);
// write only while no transaction is in flight. Zero acts as one, oversize saturates.
// Throughput: one pixel per clock unless a stalled m_ready fills the queue, set by the
// read-add-write of the two line stores (one write and one read port each, same-column
// write forwarded). Each pixel passes the queue, stage one and the result register.
// A four-entry queue between the counter front end and the line store back end
// absorbs a stalled receiver; s_ready drops only when that queue fills.
// Reset (aresetn, synchronous, active low) clears counters, row sums, the queue
// and all valid flags and restores width 320 and height 240; line store contents
// are not cleared, the first row of each frame does not read them.
// depends on: iig_pkg, iig_front, iig_queue, iig_back
`default_nettype none

module integral_image_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [iig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [iig_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [iig_pkg::PIX_W-1:0]     s_pixel,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [iig_pkg::AREA_W-1:0]         m_area_sum,
    output logic [iig_pkg::SQUARE_W-1:0]       m_square_sum,
    output logic                               m_frame_end
);

    iig_pkg::pix_entry_t push_entry, pop_entry;
    logic                push, pop, queue_full, queue_valid;

    // counters and row sums
    iig_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    // decoupling queue
    iig_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (queue_valid)
    );

    // line stores and results
    iig_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (queue_valid),
        .q_entry      (pop_entry),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_area_sum   (m_area_sum),
        .m_square_sum (m_square_sum),
        .m_frame_end  (m_frame_end)
    );

endmodule

`default_nettype wire

// File: src/iig_front.sv
// iig_front.sv: configuration registers, pixel counters and running row sums
// depends on: iig_pkg
`default_nettype none

module iig_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [iig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [iig_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [iig_pkg::PIX_W-1:0]     s_pixel,
    output logic                               push,
    output iig_pkg::pix_entry_t                push_entry,
    input  wire logic                          queue_full
);

    logic [iig_pkg::CFG_W-1:0]   width_reg, height_reg;
    logic [iig_pkg::COL_W-1:0]   col_reg, col_next, col_last;
    logic [iig_pkg::ROW_W-1:0]   row_reg, row_next, row_last;
    logic [iig_pkg::RSUM_W-1:0]  rsum_reg, rsum_next, rsum_new;
    logic [iig_pkg::RSQ_W-1:0]   rsq_reg, rsq_next, rsq_new;
    logic [2*iig_pkg::PIX_W-1:0] pix_sq;
    logic                        accept, row_end, frame_end;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= iig_pkg::WIDTH_RESET;
            height_reg <= iig_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (iig_pkg::cfg_reg_t'(cfg_index))
                iig_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                iig_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // handshake and classification
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;
    assign push      = accept;
    assign col_last  = iig_pkg::COL_W'(iig_pkg::size_last(width_reg, iig_pkg::MAX_WIDTH));
    assign row_last  = iig_pkg::ROW_W'(iig_pkg::size_last(height_reg, iig_pkg::MAX_HEIGHT));
    assign row_end   = col_reg >= col_last;
    assign frame_end = row_end && (row_reg >= row_last);

    // running row sums including this pixel
    assign pix_sq   = s_pixel * s_pixel;
    assign rsum_new = rsum_reg + iig_pkg::RSUM_W'(s_pixel);
    assign rsq_new  = rsq_reg + iig_pkg::RSQ_W'(pix_sq);

    always_comb begin
        push_entry.col       = col_reg;
        push_entry.first_row = (row_reg == '0);
        push_entry.frame_end = frame_end;
        push_entry.rsum      = rsum_new;
        push_entry.rsq       = rsq_new;
    end

    // counter and row sum update
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        rsum_next = rsum_reg;
        rsq_next  = rsq_reg;
        if (accept) begin
            if (row_end) begin
                col_next  = '0;
                rsum_next = '0;
                rsq_next  = '0;
                row_next  = frame_end ? '0 : row_reg + 1'b1;
            end else begin
                col_next  = col_reg + 1'b1;
                rsum_next = rsum_new;
                rsq_next  = rsq_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            rsum_reg <= '0;
            rsq_reg  <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rsum_reg <= rsum_next;
            rsq_reg  <= rsq_next;
        end
    end

endmodule

`default_nettype wire

// File: src/iig_queue.sv
// iig_queue.sv: short first-in first-out queue of classified pixels
// depends on: iig_pkg
`default_nettype none

module iig_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire iig_pkg::pix_entry_t  push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output iig_pkg::pix_entry_t       pop_entry,
    output logic                      not_empty
);

    iig_pkg::pix_entry_t              slot_reg [iig_pkg::QUEUE_DEPTH];
    logic [iig_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [iig_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [iig_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full      = (count_reg == iig_pkg::QCNT_W'(iig_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: src/iig_back.sv
// iig_back.sv: line stores, previous-row add and result register
// depends on: iig_pkg
`default_nettype none

module iig_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire iig_pkg::pix_entry_t          q_entry,
    output logic                              q_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [iig_pkg::AREA_W-1:0]        m_area_sum,
    output logic [iig_pkg::SQUARE_W-1:0]      m_square_sum,
    output logic                              m_frame_end
);

    // line stores
    logic [iig_pkg::AREA_W-1:0]   area_mem   [iig_pkg::MAX_WIDTH];
    logic [iig_pkg::SQUARE_W-1:0] square_mem [iig_pkg::MAX_WIDTH];

    iig_pkg::pix_entry_t          s1_entry_reg;
    logic                         s1_valid_reg, s1_valid_next;
    logic [iig_pkg::AREA_W-1:0]   rd_area_reg, byp_area_reg, prev_area, area_calc;
    logic [iig_pkg::SQUARE_W-1:0] rd_square_reg, byp_square_reg, prev_square, square_calc;
    logic                         byp_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [iig_pkg::AREA_W-1:0]   area_reg;
    logic [iig_pkg::SQUARE_W-1:0] square_reg;
    logic                         frame_end_reg;
    logic                         out_load, s1_load;

    // stage moves
    assign out_load = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s1_load  = q_valid && (!s1_valid_reg || out_load);
    assign q_pop    = s1_load;

    // previous row value, forwarded when the same column is written in the read cycle
    assign prev_area   = byp_reg ? byp_area_reg : rd_area_reg;
    assign prev_square = byp_reg ? byp_square_reg : rd_square_reg;

    assign area_calc   = iig_pkg::AREA_W'(s1_entry_reg.rsum)
                       + (s1_entry_reg.first_row ? '0 : prev_area);
    assign square_calc = iig_pkg::SQUARE_W'(s1_entry_reg.rsq)
                       + (s1_entry_reg.first_row ? '0 : prev_square);

    // line store write
    always_ff @(posedge aclk) begin
        if (out_load) begin
            area_mem[s1_entry_reg.col]   <= area_calc;
            square_mem[s1_entry_reg.col] <= square_calc;
        end
    end

    // line store read
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            rd_area_reg   <= area_mem[q_entry.col];
            rd_square_reg <= square_mem[q_entry.col];
        end
    end

    // bypass capture and stage one payload
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_entry_reg   <= q_entry;
            byp_reg        <= out_load && (s1_entry_reg.col == q_entry.col);
            byp_area_reg   <= area_calc;
            byp_square_reg <= square_calc;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            area_reg      <= area_calc;
            square_reg    <= square_calc;
            frame_end_reg <= s1_entry_reg.frame_end;
        end
    end

    // valid flags
    always_comb begin
        s1_valid_next  = s1_load ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_area_sum   = area_reg;
    assign m_square_sum = square_reg;
    assign m_frame_end  = frame_end_reg;

endmodule

`default_nettype wire

// File: src/iig_checker.sv
// iig_checker.sv: port-level assertions for the integral image generator, bound to the top
// depends on: iig_pkg, integral_image_generator_defines.svh
`default_nettype none
`include "integral_image_generator_defines.svh"

module iig_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [iig_pkg::AREA_W-1:0]    m_area_sum,
    input wire logic [iig_pkg::SQUARE_W-1:0]  m_square_sum,
    input wire logic                          m_frame_end
);

    logic [iig_pkg::SQUARE_W-1:0] area_wide;

    assign area_wide = iig_pkg::SQUARE_W'(m_area_sum);

    // no result survives reset
    `IIG_ASSERT_RST(a_no_result_after_reset, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result keeps its values
    property p_result_held;
        m_valid && !m_ready |=> m_valid && $stable(m_area_sum) && $stable(m_square_sum)
            && $stable(m_frame_end);
    endproperty
    `IIG_ASSERT(a_result_held, p_result_held, "stalled result changed")

    // every pixel satisfies p*p >= p, so the squared sum dominates the plain sum
    property p_square_lower;
        m_valid |-> m_square_sum >= area_wide;
    endproperty
    `IIG_ASSERT(a_square_lower, p_square_lower, "square sum below area sum")

    // and p*p <= 255*p bounds it from above
    property p_square_upper;
        m_valid |-> area_wide * 36'd255 >= m_square_sum;
    endproperty
    `IIG_ASSERT(a_square_upper, p_square_upper, "square sum above bound")

endmodule

bind integral_image_generator iig_checker u_iig_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_area_sum   (m_area_sum),
    .m_square_sum (m_square_sum),
    .m_frame_end  (m_frame_end)
);

`default_nettype wire

// File: tb/integral_image_generator_tb.sv
`timescale 1ns / 1ps
// integral_image_generator_tb.sv: self-checking bench for the integral image generator
// drives pixels and size writes, predicts sums and squared sums, compares every result
// depends on: iig_pkg, integral_image_generator

module integral_image_generator_tb;

    // one result transaction as predicted
    typedef struct packed {
        logic [iig_pkg::AREA_W-1:0]   area;
        logic [iig_pkg::SQUARE_W-1:0] square;
        logic                         frame_end;
    } sums_t;

    // one row of the directed sequence: a size write or a pixel
    typedef struct packed {
        bit                        is_write;
        iig_pkg::cfg_reg_t         sel;
        logic [iig_pkg::CFG_W-1:0] value;
        logic [iig_pkg::PIX_W-1:0] pixel;
        bit                        typed;
        sums_t                     want;
    } step_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [iig_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [iig_pkg::CFG_W-1:0]        cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [iig_pkg::PIX_W-1:0]        s_pixel;
    logic                             m_valid;
    logic                             m_ready;
    logic [iig_pkg::AREA_W-1:0]       m_area_sum;
    logic [iig_pkg::SQUARE_W-1:0]     m_square_sum;
    logic                             m_frame_end;

    integral_image_generator uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_area_sum   (m_area_sum),
        .m_square_sum (m_square_sum),
        .m_frame_end  (m_frame_end)
    );

    // predictor state: size registers, counters, row sums and the two line stores
    logic [iig_pkg::CFG_W-1:0] width_reg;
    logic [iig_pkg::CFG_W-1:0] height_reg;
    int                        col_pos;
    int                        row_pos;
    int                        filled_cols;
    logic [63:0]               run_area;
    logic [63:0]               run_square;
    logic [63:0]               line_area [iig_pkg::MAX_WIDTH];
    logic [63:0]               line_square [iig_pkg::MAX_WIDTH];

    sums_t expected_sums [$];
    step_t plan [$];
    int    mismatch_count;
    bit    quiet;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // zero acts as one, oversize saturates
    function automatic int effective_size(input logic [iig_pkg::CFG_W-1:0] v, input int limit);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > limit) begin
            n = limit;
        end
        return n;
    endfunction

    // advance the predictor by one pixel and return the sums it produces
    function automatic sums_t integrate_pixel(input logic [iig_pkg::PIX_W-1:0] p);
        int          w;
        int          h;
        int          col;
        logic [63:0] a;
        logic [63:0] s;
        bit          row_end;
        sums_t       r;
        w   = effective_size(width_reg, iig_pkg::MAX_WIDTH);
        h   = effective_size(height_reg, iig_pkg::MAX_HEIGHT);
        col = col_pos % iig_pkg::MAX_WIDTH;
        run_area   += 64'(p);
        run_square += 64'(p) * 64'(p);
        a = run_area;
        s = run_square;
        // first row adds nothing from the line stores
        if (row_pos != 0) begin
            a += line_area[col];
            s += line_square[col];
        end
        line_area[col]   = a;
        line_square[col] = s;
        // columns are always visited from zero upward, so the written ones form a prefix
        if (col >= filled_cols) begin
            filled_cols = col + 1;
        end
        row_end     = col_pos >= w - 1;
        r.frame_end = row_end && (row_pos >= h - 1);
        if (row_end) begin
            col_pos    = 0;
            run_area   = '0;
            run_square = '0;
            row_pos    = r.frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        r.area   = a[iig_pkg::AREA_W-1:0];
        r.square = s[iig_pkg::SQUARE_W-1:0];
        return r;
    endfunction

    // mostly short pauses, a few long ones
    function automatic int random_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // grey value with the extremes favored
    function automatic logic [iig_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return iig_pkg::PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // directed row builders
    function automatic step_t size_write(input iig_pkg::cfg_reg_t which,
                                         input logic [iig_pkg::CFG_W-1:0] v);
        step_t t;
        t          = '0;
        t.is_write = 1'b1;
        t.sel      = which;
        t.value    = v;
        return t;
    endfunction

    function automatic step_t pix(input logic [iig_pkg::PIX_W-1:0] p);
        step_t t;
        t       = '0;
        t.pixel = p;
        return t;
    endfunction

    function automatic step_t pix_known(input logic [iig_pkg::PIX_W-1:0] p,
                                        input logic [iig_pkg::AREA_W-1:0] a,
                                        input logic [iig_pkg::SQUARE_W-1:0] s,
                                        input logic fe);
        step_t t;
        t       = pix(p);
        t.typed = 1'b1;
        t.want  = '{area: a, square: s, frame_end: fe};
        return t;
    endfunction

    // append one row to the directed sequence
    function automatic void add_row(input step_t t);
        plan.insert(plan.size(), t);
    endfunction

    // one pixel transaction; the expectation is queued on acceptance
    task automatic send_pixel(input logic [iig_pkg::PIX_W-1:0] p, input bit typed,
                              input sums_t known, output logic fe);
        int    gap;
        sums_t r;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : random_pause();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (s_ready !== 1'b1);
        r = integrate_pixel(p);
        expected_sums.insert(expected_sums.size(), typed ? known : r);
        fe = r.frame_end;
    endtask

    // hold off the sender until every result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
    endtask

    // size register write, only while the block is idle
    task automatic write_size(input iig_pkg::cfg_reg_t which,
                              input logic [iig_pkg::CFG_W-1:0] v);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= v;
        @(posedge aclk);
        if (which == iig_pkg::REG_IMAGE_WIDTH) begin
            width_reg = v;
        end else begin
            height_reg = v;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver with random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0 && !quiet) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = 0;
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    stall_left = random_pause();
                end
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        sums_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                $error("result transaction with nothing expected: area_sum %0d", m_area_sum);
                mismatch_count++;
            end else begin
                want = expected_sums.pop_front();
                if (m_area_sum !== want.area) begin
                    $error("area_sum: expected %0d, got %0d", want.area, m_area_sum);
                    mismatch_count++;
                end
                if (m_square_sum !== want.square) begin
                    $error("square_sum: expected %0d, got %0d", want.square, m_square_sum);
                    mismatch_count++;
                end
                if (m_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, m_frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic                      fe;
        int                        cap;
        int                        sent;
        int                        random_items;
        logic [iig_pkg::CFG_W-1:0] v;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = iig_pkg::REG_IMAGE_WIDTH;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_pixel   = '0;
        quiet     = 1'b0;
        mismatch_count = 0;

        width_reg   = iig_pkg::WIDTH_RESET;
        height_reg  = iig_pkg::HEIGHT_RESET;
        col_pos     = 0;
        row_pos     = 0;
        filled_cols = 0;
        run_area    = '0;
        run_square  = '0;
        foreach (line_area[i]) begin
            line_area[i]   = '0;
            line_square[i] = '0;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first pixel after reset at the default size
        add_row(pix_known(8'd255, 28'd255, 36'd65025, 1'b0));
        // oversize width, zero height, then a mid-row shrink to one column
        add_row(size_write(iig_pkg::REG_IMAGE_WIDTH, 11'd2047));
        add_row(size_write(iig_pkg::REG_IMAGE_HEIGHT, 11'd0));
        add_row(pix(8'd0));
        add_row(size_write(iig_pkg::REG_IMAGE_WIDTH, 11'd0));
        add_row(pix(8'd1));
        // single column, two rows: second row adds the line store
        add_row(size_write(iig_pkg::REG_IMAGE_HEIGHT, 11'd2));
        add_row(pix_known(8'd255, 28'd255, 36'd65025, 1'b0));
        add_row(pix_known(8'd255, 28'd510, 36'd130050, 1'b1));
        // 3x3 frame, shrunk to two columns in the middle of the second row
        add_row(size_write(iig_pkg::REG_IMAGE_WIDTH, 11'd3));
        add_row(size_write(iig_pkg::REG_IMAGE_HEIGHT, 11'd3));
        add_row(pix_known(8'd0, 28'd0, 36'd0, 1'b0));
        add_row(pix(8'd128));
        add_row(pix(8'd1));
        add_row(pix(8'd255));
        add_row(size_write(iig_pkg::REG_IMAGE_WIDTH, 11'd2));
        add_row(pix(8'd7));
        add_row(pix(8'd200));
        add_row(pix(8'd3));
        // largest legal size, then mid-frame width and height cuts
        add_row(size_write(iig_pkg::REG_IMAGE_WIDTH, 11'd1024));
        add_row(size_write(iig_pkg::REG_IMAGE_HEIGHT, 11'd1024));
        add_row(pix_known(8'd255, 28'd255, 36'd65025, 1'b0));
        add_row(pix_known(8'd255, 28'd510, 36'd130050, 1'b0));
        add_row(pix_known(8'd255, 28'd765, 36'd195075, 1'b0));
        add_row(size_write(iig_pkg::REG_IMAGE_WIDTH, 11'd1));
        add_row(pix(8'd255));
        add_row(size_write(iig_pkg::REG_IMAGE_HEIGHT, 11'd1));
        add_row(pix(8'd9));

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                write_size(plan[i].sel, plan[i].value);
            end else begin
                send_pixel(plan[i].pixel, plan[i].typed, plan[i].want, fe);
            end
        end

        // random phases: new sizes while idle, then whole or partial frames
        random_items = 0;
        while (random_items < 700) begin
            wait_drained();
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0: v = '0;
                    1: v = iig_pkg::CFG_W'($urandom_range(1025, 2047));
                    2: v = iig_pkg::CFG_W'($urandom_range(64, 1024));
                    default: v = iig_pkg::CFG_W'($urandom_range(1, 12));
                endcase
                // widening past the written columns inside a frame would read unwritten entries
                if (row_pos == 0 || effective_size(v, iig_pkg::MAX_WIDTH) <= filled_cols) begin
                    write_size(iig_pkg::REG_IMAGE_WIDTH, v);
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0: v = '0;
                    1: v = iig_pkg::CFG_W'($urandom_range(1025, 2047));
                    2: v = iig_pkg::CFG_W'($urandom_range(16, 64));
                    default: v = iig_pkg::CFG_W'($urandom_range(1, 8));
                endcase
                write_size(iig_pkg::REG_IMAGE_HEIGHT, v);
            end
            // most phases run to the frame end, long frames get cut short
            cap  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 200;
            sent = 0;
            do begin
                send_pixel(random_pixel(), 1'b0, '0, fe);
                sent++;
            end while (!fe && sent < cap);
            random_items += sent;
        end

        // drain and let the pipeline settle
        quiet = 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
